// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers with clock and active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== rtl/nfi_pkg.sv =====
// ----------------------------------------------------------------------------
// Newton interpolator package
// Shared codes, limits and the result type.
// ----------------------------------------------------------------------------
package nfi_pkg;
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FEW_POINTS = 2'd1;
    localparam logic [1:0] STATUS_ZERO_STEP = 2'd2;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DIFF_W    = 48;

    localparam logic signed [63:0] ONE_Q     = 64'sh0000_0000_0001_0000;
    localparam logic        [63:0] LIMIT_MAG = 64'h2000_0000_0000_0000;
    localparam logic signed [63:0] LIMIT_POS = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] LIMIT_NEG = -64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] Q32_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Q32_MIN   = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [1:0]  status;
        logic               saturated;
    } t_result;
endpackage

// ===== rtl/nfi_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface nfi_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] query_x;

    modport source (output valid, kind, sample_x, sample_y, query_x, input ready);
    modport sink   (input valid, kind, sample_x, sample_y, query_x, output ready);
endinterface

// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one interpolation result per transfer.
// ----------------------------------------------------------------------------
interface nfi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [1:0]  status;
    logic               saturated;

    modport source (output valid, value, status, saturated, input ready);
    modport sink   (input valid, value, status, saturated, output ready);
endinterface

// ===== rtl/newton_forward_interpolator.sv =====
// Clear and load items give no result.
// An evaluation of n points gives its result after n-1 table passes of one subtraction per
// cycle over a ring of MAX_POINTS entries, one divide for u, then per term two multiplies
// and a divide.
// Early results (too few points, zero step) appear the cycle after the transfer; no new item
// is taken until the result transfer. Synchronous active-low reset clears count, origin, step.
// ----------------------------------------------------------------------------
// Newton forward-difference interpolator
// Collects equally spaced Q16.16 samples and evaluates the Newton forward
// polynomial at a query point with one shared multiplier and divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module newton_forward_interpolator
    import nfi_pkg::*;
#(
    parameter int MAX_POINTS = 8
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    nfi_in_if.sink     i_in,
    nfi_out_if.source  o_out
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = $clog2(MAX_POINTS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIFF = 6'b000010,
        S_UDIV = 6'b000100,
        S_CMUL = 6'b001000,
        S_CDIV = 6'b010000,
        S_TMUL = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sample store has no reset; only entries below the point count affect the result.
    logic signed [31:0]       r_samples [MAX_POINTS];
    // Difference ring: the head entry r_diff[0] is the one being worked on.
    logic signed [DIFF_W-1:0] r_diff    [MAX_POINTS];
    logic signed [DIFF_W-1:0] r_prev;

    logic [CW-1:0]      r_count;
    logic signed [15:0] r_first;
    logic signed [16:0] r_step;
    logic signed [31:0] r_query;
    logic [CW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic signed [63:0] r_u;
    logic signed [63:0] r_coef;
    logic signed [63:0] r_acc;
    logic               r_hit;
    logic               r_ovalid;
    t_result            r_res;

    logic               w_in_xfer;
    logic               w_mul_start;
    logic signed [63:0] w_mul_a;
    logic signed [63:0] w_mul_b;
    logic               w_mul_done;
    logic signed [63:0] w_mul_p;
    logic               w_mul_hit;
    logic               w_div_start;
    logic signed [63:0] w_div_a;
    logic signed [17:0] w_div_b;
    logic               w_div_done;
    logic signed [63:0] w_div_q;
    logic signed [63:0] w_num;
    logic signed [63:0] w_head;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_acc_c;
    logic               w_clamp;
    logic               w_hit_all;
    logic               w_last;
    logic               w_rotate;
    logic               w_active;
    logic signed [DIFF_W-1:0] w_new;
    t_result            w_final;
    logic               w_few_busy;
    logic               w_idx_ok;
    logic               w_mul_wait;

    assign w_in_xfer = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;

    // Numerator of u: query minus origin, both in Q16.16.
    assign w_num  = 64'(r_query) - (64'(r_first) <<< FRAC_BITS);
    assign w_head = 64'(r_diff[0]);
    assign w_last = r_i == r_count - CW'(1);

    // One forward-difference step per cycle while the ring turns.
    assign w_active = ({{(CW-IW){1'b0}}, r_j} >= r_i)
                   && ({{(CW-IW){1'b0}}, r_j} < r_count);
    assign w_new    = w_active ? r_diff[0] - r_prev : r_diff[0];

    // Partial sum is clamped to +-2^61 after every term.
    always_comb begin
        w_sum   = r_acc + w_mul_p;
        w_clamp = (w_sum > LIMIT_POS) || (w_sum < LIMIT_NEG);
        w_acc_c = (w_sum > LIMIT_POS) ? LIMIT_POS
                : ((w_sum < LIMIT_NEG) ? LIMIT_NEG : w_sum);
        w_hit_all = r_hit || w_mul_hit || w_clamp;
        w_final.status = STATUS_OK;
        if (w_hit_all || (w_acc_c > Q32_MAX) || (w_acc_c < Q32_MIN)) begin
            w_final.saturated = 1'b1;
            w_final.value     = w_acc_c[63] ? Q32_MIN[31:0] : Q32_MAX[31:0];
        end else begin
            w_final.saturated = 1'b0;
            w_final.value     = w_acc_c[31:0];
        end
    end

    // Sequencer for the shared units.
    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = ONE_Q;
        w_mul_b     = r_u;
        w_div_start = 1'b0;
        w_div_a     = w_num;
        w_div_b     = 18'(r_step);
        w_rotate    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_in.kind == KIND_EVAL && r_count >= CW'(2)
                        && r_step != 17'sd0) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                w_rotate = 1'b1;
                if (r_j == IW'(MAX_POINTS - 1) && w_last) begin
                    w_div_start = 1'b1;
                    n_state     = S_UDIV;
                end
            end
            S_UDIV: begin
                if (w_div_done) begin
                    // First coefficient factor is u itself.
                    w_mul_start = 1'b1;
                    w_mul_a     = ONE_Q;
                    w_mul_b     = w_div_q;
                    w_rotate    = 1'b1;
                    n_state     = S_CMUL;
                end
            end
            S_CMUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_a     = w_mul_p;
                    w_div_b     = 18'(r_i);
                    n_state     = S_CDIV;
                end
            end
            S_CDIV: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = w_div_q;
                    w_mul_b     = w_head;
                    n_state     = S_TMUL;
                end
            end
            S_TMUL: begin
                if (w_mul_done) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // Next factor is u - i with the current i.
                        w_mul_start = 1'b1;
                        w_mul_a     = r_coef;
                        w_mul_b     = r_u - (64'(r_i) <<< FRAC_BITS);
                        w_rotate    = 1'b1;
                        n_state     = S_CMUL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_first  <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        priority if (i_in.kind == KIND_CLEAR) begin
                            r_count <= '0;
                        end else if (i_in.kind == KIND_LOAD) begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                if (r_count == CW'(0)) begin
                                    r_first <= i_in.sample_x;
                                end else if (r_count == CW'(1)) begin
                                    r_step <= 17'(i_in.sample_x) - 17'(r_first);
                                end
                                r_count <= r_count + CW'(1);
                            end
                        end else if (i_in.kind == KIND_EVAL) begin
                            r_hit <= 1'b0;
                            r_i   <= CW'(1);
                            r_j   <= '0;
                            if (r_count < CW'(2)) begin
                                r_ovalid <= 1'b1;
                            end else if (r_step == 17'sd0) begin
                                r_ovalid <= 1'b1;
                            end
                        end else begin
                            r_count <= r_count;
                        end
                    end
                end
                S_DIFF: begin
                    if (r_j == IW'(MAX_POINTS - 1)) begin
                        r_j <= '0;
                        if (!w_last) begin
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                    if (r_j == IW'(MAX_POINTS - 1) && w_last) begin
                        r_i <= CW'(1);
                    end
                end
                S_TMUL: begin
                    if (w_mul_done) begin
                        r_hit <= w_hit_all;
                        if (w_last) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            r_i <= r_i + CW'(1);
                        end
                    end
                end
                S_CMUL: begin
                    if (w_mul_done) begin
                        r_hit <= r_hit | w_mul_hit;
                    end
                end
                S_UDIV, S_CDIV: begin
                    r_hit <= r_hit;
                end
                default: begin
                    r_hit <= r_hit;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_xfer) begin
            if (i_in.kind == KIND_LOAD && r_count < CW'(MAX_POINTS)) begin
                r_samples[r_count[IW-1:0]] <= i_in.sample_y;
            end
            if (i_in.kind == KIND_EVAL) begin
                r_query <= i_in.query_x;
                for (int k = 0; k < MAX_POINTS; k++) begin
                    r_diff[k] <= DIFF_W'(r_samples[k]);
                end
                if (r_count < CW'(2)) begin
                    r_res <= '{value: '0, status: STATUS_FEW_POINTS, saturated: 1'b0};
                end else if (r_step == 17'sd0) begin
                    r_res <= '{value: '0, status: STATUS_ZERO_STEP, saturated: 1'b0};
                end
            end
        end
        if (w_rotate) begin
            for (int k = 0; k < MAX_POINTS - 1; k++) begin
                r_diff[k] <= r_diff[k + 1];
            end
            r_diff[MAX_POINTS - 1] <= (r_state == S_DIFF) ? w_new : r_diff[0];
        end
        if (r_state == S_DIFF) begin
            r_prev <= r_diff[0];
        end
        if (r_state == S_UDIV && w_div_done) begin
            r_u   <= w_div_q;
            r_acc <= w_head;
        end
        if (r_state == S_CDIV && w_div_done) begin
            r_coef <= w_div_q;
        end
        if (r_state == S_TMUL && w_mul_done) begin
            r_acc <= w_acc_c;
            if (w_last) begin
                r_res <= w_final;
            end
        end
    end

    nfi_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_p),
        .o_hit     (w_mul_hit)
    );

    nfi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_out.valid     = r_ovalid;
    assign o_out.value     = r_res.value;
    assign o_out.status    = r_res.status;
    assign o_out.saturated = r_res.saturated;

    assign w_few_busy = (r_state != S_IDLE) && (r_count < CW'(2));
    assign w_idx_ok   = (r_i != CW'(0)) && (r_i < r_count);
    assign w_mul_wait = (r_state == S_CMUL) || (r_state == S_TMUL);

    // The point count never passes the store capacity.
    `ASSERT_CLK(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MAX_POINTS), "point count overflow")
    // An evaluation in progress always has at least two points.
    `ASSERT_NEVER(a_eval_points, i_clk, i_rst_n, w_few_busy, "evaluation with too few points")
    // Multiplier results arrive only while the sequencer waits for them.
    `ASSERT_CLK(a_mul_owner, i_clk, i_rst_n, w_mul_done |-> w_mul_wait, "unexpected product")
    // The series index stays inside the loaded points.
    `ASSERT_CLK(a_term_index, i_clk, i_rst_n, (r_state == S_CMUL) |-> w_idx_ok, "bad series index")
endmodule

// ===== rtl/nfi_mul.sv =====
// ----------------------------------------------------------------------------
// Iterative fractional multiplier
// Signed Q16.16 product, 16 multiplier bits per cycle, clamped to +-2^61.
// ----------------------------------------------------------------------------
module nfi_mul
    import nfi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_product,
    output logic               o_hit
);
    logic         r_busy;
    logic         r_done;
    logic [1:0]   r_cnt;
    logic         r_neg;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic [127:0] r_prod;
    logic [79:0]  w_pp;
    logic [63:0]  w_mag;

    // Multiplier digits are consumed most significant first.
    assign w_pp = r_ua * r_ub[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua   <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub   <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg  <= i_a[63] ^ i_b[63];
            r_prod <= '0;
        end else if (r_busy) begin
            r_prod <= (r_prod << 16) + {48'd0, w_pp};
            r_ub   <= r_ub << 16;
        end
    end

    always_comb begin
        o_hit     = (|r_prod[127:80]) || (r_prod[79:16] > LIMIT_MAG);
        w_mag     = o_hit ? LIMIT_MAG : r_prod[79:16];
        o_product = r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    assign o_done = r_done;
endmodule

// ===== rtl/nfi_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Signed 64 by 18 bit restoring division, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module nfi_div
    import nfi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic signed [17:0] i_divisor,
    output logic               o_done,
    output logic signed [63:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_dvd;
    logic [17:0] r_rem;
    logic [16:0] r_dsr;
    logic [17:0] w_sh;
    logic        w_ge;
    logic [17:0] w_dsr_mag;

    assign w_dsr_mag = i_divisor[17] ? 18'(-i_divisor) : i_divisor;
    assign w_sh      = {r_rem[16:0], r_dvd[63]};
    assign w_ge      = w_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend[63] ? 64'(-i_dividend) : i_dividend;
            r_dsr <= w_dsr_mag[16:0];
            r_rem <= '0;
            r_neg <= i_dividend[63] ^ i_divisor[17];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sh - {1'b0, r_dsr} : w_sh;
            r_dvd <= {r_dvd[62:0], w_ge};
        end
    end

    assign o_quotient = r_neg ? -$signed(r_dvd) : $signed(r_dvd);
    assign o_done     = r_done;
endmodule
